[src/trd_pkg.sv]
`default_nettype none

package trd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int CORDIC_W    = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_TILT_STOP_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REST_RADIUS_SQ      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STEP_ANGLE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_GAIN          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_MS           = 3'd4;

  localparam logic [14:0] TILT_STOP_RESET = 15'd1920;
  localparam logic [30:0] REST_RADIUS_RESET = 31'd589824;
  localparam logic [14:0] MIN_STEP_RESET = 15'd522;
  localparam logic [9:0]  LEVEL_GAIN_RESET = 10'd251;
  localparam logic [15:0] SETTLE_RESET = 16'd150;

  localparam logic [23:0] BRIGHT_RESET = 24'h7F0000;
  localparam logic [23:0] LEVEL_MIN_Q  = 24'h010000;
  localparam logic [23:0] LEVEL_MAX_Q  = 24'hFE0000;
  localparam logic [7:0]  LEVEL_RESET  = 8'd127;

  localparam logic [31:0] TURN_QUARTER       = 32'h40000000;
  localparam logic [31:0] TURN_THREE_QUARTER = 32'hC0000000;

  typedef struct packed {
    logic [14:0] tilt_stop_threshold;
    logic [30:0] rest_radius_sq;
    logic [14:0] min_step_angle;
    logic [9:0]  level_gain;
    logic [15:0] settle_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_WAKE,
    KIND_IGNORE,
    KIND_TILT,
    KIND_SAMPLE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        now_ms;
    logic [30:0]        x_sq;
    logic [30:0]        y_sq;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_DIFF,
    ST_DONE
  } back_state_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A2F;
      5'd19: val = 32'h00000517;
      5'd20: val = 32'h0000028B;
      5'd21: val = 32'h00000145;
      5'd22: val = 32'h000000A2;
      5'd23: val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[src/trd_front.sv]
`default_nettype none

module trd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire trd_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic               in_window_open,
  output logic                    f_valid,
  output trd_pkg::entry_t         f_data,
  input  wire logic               q_ready
);

  logic            f_valid_r;
  logic            f_valid_nxt;
  trd_pkg::entry_t f_data_r;
  trd_pkg::entry_t f_data_nxt;
  logic [16:0]     z_mag;
  logic signed [31:0] x_prod;
  logic signed [31:0] y_prod;
  trd_pkg::kind_t  kind;
  logic            accept;
  logic            push;

  assign z_mag  = in_accel_z[15] ? (17'd0 - {1'b1, in_accel_z}) : {1'b0, in_accel_z};
  assign x_prod = in_accel_x * in_accel_x;
  assign y_prod = in_accel_y * in_accel_y;

  always_comb begin
    if (!in_mode) begin
      kind = trd_pkg::KIND_WAKE;
    end else if (in_window_open) begin
      kind = trd_pkg::KIND_IGNORE;
    end else if (z_mag > {2'b00, cfg.tilt_stop_threshold}) begin
      kind = trd_pkg::KIND_TILT;
    end else begin
      kind = trd_pkg::KIND_SAMPLE;
    end
  end

  assign push     = f_valid_r && q_ready;
  assign in_ready = !f_valid_r || q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_data_nxt  = f_data_r;
    if (accept) begin
      f_valid_nxt       = 1'b1;
      f_data_nxt.kind   = kind;
      f_data_nxt.x      = in_accel_x;
      f_data_nxt.y      = in_accel_y;
      f_data_nxt.now_ms = in_now_ms;
      f_data_nxt.x_sq   = x_prod[30:0];
      f_data_nxt.y_sq   = y_prod[30:0];
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_data_r <= f_data_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_data  = f_data_r;

endmodule

`default_nettype wire

[src/trd_queue.sv]
`default_nettype none

module trd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire trd_pkg::entry_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output trd_pkg::entry_t      pop_data
);

  trd_pkg::entry_t slot_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/trd_back.sv]
`default_nettype none

module trd_back #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire trd_pkg::cfg_t   cfg,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire trd_pkg::entry_t pop_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_send_level,
  output logic [7:0]           out_level,
  output logic                 out_stop_dimming,
  output logic                 out_extend_wake
);

  localparam int CW = trd_pkg::CORDIC_W;
  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int PW = ANGLE_BITS + 11;
  localparam int MW = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;
  localparam int SW = ((PW > 25) ? PW : 25) + 1;
  localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);
  localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);

  trd_pkg::back_state_t state_r;
  trd_pkg::back_state_t state_nxt;

  trd_pkg::entry_t cur_r;
  trd_pkg::entry_t cur_nxt;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_r;
  logic signed [CW-1:0] y_nxt;
  logic [31:0]          acc_r;
  logic [31:0]          acc_nxt;
  logic [IW-1:0]        it_r;
  logic [IW-1:0]        it_nxt;
  logic                 rest_r;
  logic                 rest_nxt;
  logic                 move_r;
  logic                 move_nxt;
  logic [ANGLE_BITS-1:0] angle_r;
  logic [ANGLE_BITS-1:0] angle_nxt;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  prod_nxt;

  logic [ANGLE_BITS-1:0] prev_angle_r;
  logic [ANGLE_BITS-1:0] prev_angle_nxt;
  logic [23:0]           bright_r;
  logic [23:0]           bright_nxt;
  logic [7:0]            last_sent_r;
  logic [7:0]            last_sent_nxt;
  logic [31:0]           last_move_r;
  logic [31:0]           last_move_nxt;
  logic                  first_r;
  logic                  first_nxt;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_send_r;
  logic       out_send_nxt;
  logic [7:0] out_level_r;
  logic [7:0] out_level_nxt;
  logic       out_stop_r;
  logic       out_stop_nxt;
  logic       out_extend_r;
  logic       out_extend_nxt;

  logic done_fire;

  logic signed [CW-1:0]  x_ext;
  logic signed [CW-1:0]  y_ext;
  logic [31:0]           radius_sum;
  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic [31:0]           acc_round;
  logic [ANGLE_BITS-1:0] angle_w;
  logic [ANGLE_BITS-1:0] diff_w;
  logic [ANGLE_BITS-1:0] mag_w;
  logic signed [SW-1:0]  bright_ext;
  logic signed [SW-1:0]  sum_w;
  logic signed [SW-1:0]  max_ext;
  logic signed [SW-1:0]  min_ext;
  logic [23:0]           bright_sat;
  logic [7:0]            target;
  logic                  changed;
  logic                  settled;

  assign x_ext      = {{(CW-16){cur_r.x[15]}}, cur_r.x};
  assign y_ext      = {{(CW-16){cur_r.y[15]}}, cur_r.y};
  assign radius_sum = {1'b0, cur_r.x_sq} + {1'b0, cur_r.y_sq};
  assign xs         = x_r >>> it_r;
  assign ys         = y_r >>> it_r;
  assign acc_round  = acc_r + ROUND_HALF;
  assign angle_w    = acc_round[31 -: ANGLE_BITS];
  assign diff_w     = angle_w - prev_angle_r;
  assign mag_w      = diff_w[ANGLE_BITS-1] ? (~diff_w + 1'b1) : diff_w;

  assign bright_ext = $signed({{(SW-24){1'b0}}, bright_r});
  assign max_ext    = $signed({{(SW-24){1'b0}}, trd_pkg::LEVEL_MAX_Q});
  assign min_ext    = $signed({{(SW-24){1'b0}}, trd_pkg::LEVEL_MIN_Q});
  assign sum_w      = bright_ext + SW'(prod_r);

  always_comb begin
    if (sum_w > max_ext) begin
      bright_sat = trd_pkg::LEVEL_MAX_Q;
    end else if (sum_w < min_ext) begin
      bright_sat = trd_pkg::LEVEL_MIN_Q;
    end else begin
      bright_sat = sum_w[23:0];
    end
  end

  assign target  = bright_r[23:16];
  assign changed = (target != last_sent_r);
  assign settled = ((cur_r.now_ms - last_move_r) > {16'd0, cfg.settle_ms});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trd_pkg::ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_data.kind == trd_pkg::KIND_SAMPLE) ? trd_pkg::ST_PREP
                                                              : trd_pkg::ST_DONE;
        end
      end
      trd_pkg::ST_PREP: begin
        state_nxt = trd_pkg::ST_ITER;
      end
      trd_pkg::ST_ITER: begin
        if (it_r == LAST_IT) begin
          state_nxt = trd_pkg::ST_DIFF;
        end
      end
      trd_pkg::ST_DIFF: begin
        state_nxt = trd_pkg::ST_DONE;
      end
      trd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = trd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      trd_pkg::ST_IDLE: pop_ready = 1'b1;
      trd_pkg::ST_DONE: done_fire = !out_valid_r || out_ready;
      default: begin
        pop_ready = 1'b0;
        done_fire = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_nxt        = cur_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    acc_nxt        = acc_r;
    it_nxt         = it_r;
    rest_nxt       = rest_r;
    move_nxt       = move_r;
    angle_nxt      = angle_r;
    prod_nxt       = prod_r;
    prev_angle_nxt = prev_angle_r;
    bright_nxt     = bright_r;
    last_sent_nxt  = last_sent_r;
    last_move_nxt  = last_move_r;
    first_nxt      = first_r;
    out_send_nxt   = out_send_r;
    out_level_nxt  = out_level_r;
    out_stop_nxt   = out_stop_r;
    out_extend_nxt = out_extend_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;

    if (pop_ready && pop_valid) begin
      cur_nxt = pop_data;
    end

    if (state_r == trd_pkg::ST_PREP) begin
      rest_nxt = (radius_sum < {1'b0, cfg.rest_radius_sq});
      it_nxt   = '0;
      if (!cur_r.x[15]) begin
        x_nxt   = x_ext;
        y_nxt   = y_ext;
        acc_nxt = 32'd0;
      end else if (!cur_r.y[15]) begin
        x_nxt   = y_ext;
        y_nxt   = -x_ext;
        acc_nxt = trd_pkg::TURN_QUARTER;
      end else begin
        x_nxt   = -y_ext;
        y_nxt   = x_ext;
        acc_nxt = trd_pkg::TURN_THREE_QUARTER;
      end
    end

    if (state_r == trd_pkg::ST_ITER) begin
      it_nxt = it_r + 1'b1;
      if (!y_r[CW-1]) begin
        x_nxt   = x_r + ys;
        y_nxt   = y_r - xs;
        acc_nxt = acc_r + trd_pkg::atan_turns(5'(it_r));
      end else begin
        x_nxt   = x_r - ys;
        y_nxt   = y_r + xs;
        acc_nxt = acc_r - trd_pkg::atan_turns(5'(it_r));
      end
    end

    if (state_r == trd_pkg::ST_DIFF) begin
      angle_nxt = angle_w;
      move_nxt  = (MW'(mag_w) >= MW'(cfg.min_step_angle));
      prod_nxt  = $signed(diff_w) * $signed({1'b0, cfg.level_gain});
    end

    if (done_fire) begin
      out_valid_nxt  = 1'b1;
      out_send_nxt   = 1'b0;
      out_level_nxt  = 8'd0;
      out_stop_nxt   = 1'b0;
      out_extend_nxt = 1'b0;
      case (cur_r.kind)
        trd_pkg::KIND_WAKE: begin
          first_nxt     = 1'b1;
          last_move_nxt = cur_r.now_ms;
        end
        trd_pkg::KIND_TILT: begin
          out_stop_nxt = 1'b1;
          if (changed) begin
            last_sent_nxt = target;
            out_send_nxt  = 1'b1;
            out_level_nxt = target;
          end
        end
        trd_pkg::KIND_SAMPLE: begin
          if (rest_r) begin
            prev_angle_nxt = angle_r;
            last_move_nxt  = cur_r.now_ms;
          end else if (first_r) begin
            prev_angle_nxt = angle_r;
            first_nxt      = 1'b0;
          end else if (move_r) begin
            bright_nxt     = bright_sat;
            prev_angle_nxt = angle_r;
            last_move_nxt  = cur_r.now_ms;
            out_extend_nxt = 1'b1;
          end else if (settled && changed) begin
            last_sent_nxt = target;
            out_send_nxt  = 1'b1;
            out_level_nxt = target;
          end
        end
        default: begin
          out_send_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= trd_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_angle_r <= '0;
      bright_r     <= trd_pkg::BRIGHT_RESET;
      last_sent_r  <= trd_pkg::LEVEL_RESET;
      last_move_r  <= 32'd0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_angle_r <= prev_angle_nxt;
      bright_r     <= bright_nxt;
      last_sent_r  <= last_sent_nxt;
      last_move_r  <= last_move_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    acc_r        <= acc_nxt;
    it_r         <= it_nxt;
    rest_r       <= rest_nxt;
    move_r       <= move_nxt;
    angle_r      <= angle_nxt;
    prod_r       <= prod_nxt;
    out_send_r   <= out_send_nxt;
    out_level_r  <= out_level_nxt;
    out_stop_r   <= out_stop_nxt;
    out_extend_r <= out_extend_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_send_level   = out_send_r;
  assign out_level        = out_level_r;
  assign out_stop_dimming = out_stop_r;
  assign out_extend_wake  = out_extend_r;

endmodule

`default_nettype wire

[src/tilt_rotation_dimmer.sv]
// A sample goes through the angle calculation in the iterative CORDIC of the back end,
// which runs one rotation per cycle; wake, ignored and tilt transactions skip it.
// The front register and the two-entry queue can take new transactions while the back
// end is still busy with an earlier one, which it handles one at a time.
// Reset is synchronous and active low; it loads the register defaults and the dimmer
// state at once, with no clearing pass.
`default_nettype none

module tilt_rotation_dimmer #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [trd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [trd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_mode,
  input  wire logic signed [15:0]                  in_accel_x,
  input  wire logic signed [15:0]                  in_accel_y,
  input  wire logic signed [15:0]                  in_accel_z,
  input  wire logic [31:0]                         in_now_ms,
  input  wire logic                                in_window_open,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_send_level,
  output logic [7:0]                               out_level,
  output logic                                     out_stop_dimming,
  output logic                                     out_extend_wake
);

  trd_pkg::cfg_t   cfg_r;
  trd_pkg::cfg_t   cfg_nxt;
  logic            f_valid;
  trd_pkg::entry_t f_data;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;
  trd_pkg::entry_t q_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        trd_pkg::REG_TILT_STOP_THRESHOLD: cfg_nxt.tilt_stop_threshold = cfg_wdata[14:0];
        trd_pkg::REG_REST_RADIUS_SQ:      cfg_nxt.rest_radius_sq      = cfg_wdata[30:0];
        trd_pkg::REG_MIN_STEP_ANGLE:      cfg_nxt.min_step_angle      = cfg_wdata[14:0];
        trd_pkg::REG_LEVEL_GAIN:          cfg_nxt.level_gain          = cfg_wdata[9:0];
        trd_pkg::REG_SETTLE_MS:           cfg_nxt.settle_ms           = cfg_wdata[15:0];
        default:                          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_stop_threshold <= trd_pkg::TILT_STOP_RESET;
      cfg_r.rest_radius_sq      <= trd_pkg::REST_RADIUS_RESET;
      cfg_r.min_step_angle      <= trd_pkg::MIN_STEP_RESET;
      cfg_r.level_gain          <= trd_pkg::LEVEL_GAIN_RESET;
      cfg_r.settle_ms           <= trd_pkg::SETTLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  trd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .in_now_ms      (in_now_ms),
    .in_window_open (in_window_open),
    .f_valid        (f_valid),
    .f_data         (f_data),
    .q_ready        (q_ready)
  );

  trd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  trd_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .pop_valid        (q_valid),
    .pop_ready        (q_pop),
    .pop_data         (q_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_send_level   (out_send_level),
    .out_level        (out_level),
    .out_stop_dimming (out_stop_dimming),
    .out_extend_wake  (out_extend_wake)
  );

`ifndef ASSERT_OFF
  a_level_only_when_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_send_level) |-> (out_level == 8'd0))
    else $error("Level is non-zero on a transaction that sends nothing.");

  a_sent_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_level) |-> ((out_level != 8'd0) && (out_level != 8'd255)))
    else $error("Sent level lies outside the dimmer range.");

  a_stop_excludes_extend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_stop_dimming && out_extend_wake))
    else $error("A tilt stop and a wake extension appear in one transaction.");
`endif

endmodule

`default_nettype wire

[bench/tilt_rotation_dimmer_tb.sv]
`timescale 1ns / 1ps

module tilt_rotation_dimmer_tb;

  localparam int STEPS = 16;
  localparam int IDLE_PCT = 29;
  localparam logic [15:0][31:0] ATAN_STEP = {
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };
  localparam longint BRIGHT_MIN = 64'sd65536;
  localparam longint BRIGHT_MAX = 64'sd254 * 64'sd65536;

  typedef struct packed {
    logic        mode;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [31:0] now;
    logic        window;
  } sample_t;

  typedef struct packed {
    logic       send;
    logic [7:0] level;
    logic       stop;
    logic       extend;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [trd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [31:0] in_now_ms = '0;
  logic in_window_open = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_send_level;
  logic [7:0] out_level;
  logic out_stop_dimming;
  logic out_extend_wake;

  sample_t pending_samples[$];
  verdict_t awaited_verdicts[$];
  sample_t on_bus;
  verdict_t got, want;

  trd_pkg::cfg_t settings = '{trd_pkg::TILT_STOP_RESET, trd_pkg::REST_RADIUS_RESET,
                              trd_pkg::MIN_STEP_RESET, trd_pkg::LEVEL_GAIN_RESET,
                              trd_pkg::SETTLE_RESET};
  logic [15:0] prev_angle = '0;
  longint bright = 64'sd127 * 64'sd65536;
  logic [7:0] last_level = trd_pkg::LEVEL_RESET;
  logic [31:0] move_time = '0;
  logic armed = 1'b0;

  logic calm = 1'b0;
  int errors = 0;
  int accepted = 0;
  int results = 0;
  int sends = 0;
  int stops = 0;
  int extensions = 0;
  int settings_used = 1;
  int hold_left = 0;
  int phase_items = 0;
  logic [31:0] clock_ms = '0;
  int angle_units = 0;

  tilt_rotation_dimmer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_now_ms(in_now_ms), .in_window_open(in_window_open),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_send_level(out_send_level), .out_level(out_level),
    .out_stop_dimming(out_stop_dimming), .out_extend_wake(out_extend_wake)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] cordic_angle(input longint x, input longint y);
    longint cx, cy, t, xs, ys;
    logic [31:0] acc;
    acc = '0;
    cx = x;
    cy = y;
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; acc = trd_pkg::TURN_QUARTER;
      end else begin
        t = cx; cx = -cy; cy = t; acc = trd_pkg::TURN_THREE_QUARTER;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx = cx + ys; cy = cy - xs; acc = acc + ATAN_STEP[i];
      end else begin
        cx = cx - ys; cy = cy + xs; acc = acc - ATAN_STEP[i];
      end
    end
    acc = acc + 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic verdict_t level_change();
    verdict_t r;
    logic [7:0] target;
    r = '0;
    target = 8'(bright >>> 16);
    if (target != last_level) begin
      last_level = target;
      r.send = 1'b1;
      r.level = target;
    end
    return r;
  endfunction

  function automatic verdict_t predict_dimmer_output(input sample_t s);
    verdict_t r;
    longint x, y, z, mag, delta, b, thr, rr, min_step, gain;
    longint radius;
    logic [15:0] ang, d;
    logic [31:0] quiet;
    r = '0;
    thr = settings.tilt_stop_threshold;
    rr = settings.rest_radius_sq;
    min_step = settings.min_step_angle;
    gain = settings.level_gain;
    if (!s.mode) begin
      armed = 1'b1;
      move_time = s.now;
      return r;
    end
    if (s.window) return r;
    x = $signed(s.ax);
    y = $signed(s.ay);
    z = $signed(s.az);
    mag = (z < 0) ? -z : z;
    if (mag > thr) begin
      r = level_change();
      r.stop = 1'b1;
      return r;
    end
    radius = x * x + y * y;
    ang = cordic_angle(x, y);
    if (radius < rr) begin
      prev_angle = ang;
      move_time = s.now;
      return r;
    end
    if (armed) begin
      prev_angle = ang;
      armed = 1'b0;
      return r;
    end
    d = ang - prev_angle;
    delta = $signed(d);
    mag = (delta < 0) ? -delta : delta;
    quiet = s.now - move_time;
    if (mag >= min_step) begin
      b = bright + delta * gain;
      if (b > BRIGHT_MAX) b = BRIGHT_MAX;
      if (b < BRIGHT_MIN) b = BRIGHT_MIN;
      bright = b;
      prev_angle = ang;
      move_time = s.now;
      r.extend = 1'b1;
    end else if (quiet > {16'h0000, settings.settle_ms}) begin
      r = level_change();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_verdicts.push_back(predict_dimmer_output(on_bus));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_mode <= on_bus.mode;
          in_accel_x <= on_bus.ax;
          in_accel_y <= on_bus.ay;
          in_accel_z <= on_bus.az;
          in_now_ms <= on_bus.now;
          in_window_open <= on_bus.window;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_send_level, out_level, out_stop_dimming, out_extend_wake};
        if (awaited_verdicts.size() == 0) begin
          errors++;
          $display("%0t: result with none expected,", $time,
                   " actual send=%0b level=%0d stop=%0b extend=%0b",
                   got.send, got.level, got.stop, got.extend);
        end else begin
          want = awaited_verdicts.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch, expected send=%0b level=%0d stop=%0b extend=%0b,",
                     $time, want.send, want.level, want.stop, want.extend,
                     " actual send=%0b level=%0d stop=%0b extend=%0b",
                     got.send, got.level, got.stop, got.extend);
          end
        end
        results++;
        if (got.send) sends++;
        if (got.stop) stops++;
        if (got.extend) extensions++;
        if (results == 250 || results == 1100) hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  task automatic push_item(input logic mode, input int x, input int y, input int z,
                           input logic [31:0] now, input logic win);
    sample_t s;
    s.mode = mode;
    s.ax = 16'(x);
    s.ay = 16'(y);
    s.az = 16'(z);
    s.now = now;
    s.window = win;
    pending_samples.push_back(s);
    phase_items++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || awaited_verdicts.size() != 0);
  endtask

  task automatic load_settings(input trd_pkg::cfg_t c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= trd_pkg::REG_TILT_STOP_THRESHOLD;
    cfg_wdata <= trd_pkg::CFG_DATA_W'(c.tilt_stop_threshold);
    @(posedge clk);
    cfg_index <= trd_pkg::REG_REST_RADIUS_SQ;
    cfg_wdata <= c.rest_radius_sq;
    @(posedge clk);
    cfg_index <= trd_pkg::REG_MIN_STEP_ANGLE;
    cfg_wdata <= trd_pkg::CFG_DATA_W'(c.min_step_angle);
    @(posedge clk);
    cfg_index <= trd_pkg::REG_LEVEL_GAIN;
    cfg_wdata <= trd_pkg::CFG_DATA_W'(c.level_gain);
    @(posedge clk);
    cfg_index <= trd_pkg::REG_SETTLE_MS;
    cfg_wdata <= trd_pkg::CFG_DATA_W'(c.settle_ms);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings = c;
    settings_used++;
  endtask

  function automatic trd_pkg::cfg_t random_settings();
    trd_pkg::cfg_t c;
    c.tilt_stop_threshold = ($urandom_range(99) < 20) ? 15'($urandom_range(0, 32767))
                                                      : 15'($urandom_range(1500, 12000));
    c.rest_radius_sq = 31'($urandom_range(0, 2000000));
    c.min_step_angle = 15'($urandom_range(0, 4000));
    c.level_gain = 10'($urandom_range(0, 1023));
    c.settle_ms = 16'($urandom_range(0, 500));
    return c;
  endfunction

  task automatic rotation_session(input int n);
    int thr, zv, step, r, x, y, pick;
    real theta;
    thr = settings.tilt_stop_threshold;
    if ($urandom_range(99) < 15) clock_ms = $urandom;
    push_item(1'b0, int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)),
              clock_ms, 1'($urandom));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 25) clock_ms += settings.settle_ms + $urandom_range(1, 200);
      else clock_ms += $urandom_range(0, 60);
      zv = $urandom_range(0, thr > 32767 ? 32767 : thr);
      if ($urandom_range(1)) zv = -zv;
      if (pick < 6) begin
        push_item(1'b1, int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)),
                  clock_ms, 1'b1);
      end else if (pick < 12) begin
        if (thr >= 32767) zv = -32768;
        else zv = $urandom_range(thr + 1, 32767);
        if ($urandom_range(1) && zv != -32768) zv = -zv;
        push_item(1'b1, int'(16'($urandom)), int'(16'($urandom)), zv, clock_ms, 1'b0);
      end else if (pick < 18) begin
        push_item(1'b1, $urandom_range(0, 1400) - 700, $urandom_range(0, 1400) - 700, zv,
                  clock_ms, 1'b0);
      end else if (pick < 22) begin
        push_item(1'($urandom), int'(16'($urandom)), int'(16'($urandom)),
                  int'(16'($urandom)), $urandom, 1'($urandom_range(99) < 20));
      end else begin
        if ($urandom_range(99) < 55) step = $urandom_range(0, 2 * settings.min_step_angle + 2);
        else step = $urandom_range(0, 32768);
        if ($urandom_range(1)) step = -step;
        angle_units = (angle_units + step) & 16'hFFFF;
        theta = angle_units * 2.0 * 3.14159265358979 / 65536.0;
        r = $urandom_range(800, 32000);
        x = $rtoi(r * $cos(theta));
        y = $rtoi(r * $sin(theta));
        push_item(1'b1, x, y, zv, clock_ms, 1'b0);
      end
    end
  endtask

  task automatic random_phase(input int n);
    phase_items = 0;
    while (phase_items < n) rotation_session($urandom_range(4, 40));
  endtask

  initial begin
    int hx, hy;
    logic [15:0] gap;
    hx = 1000;
    hy = 0;
    for (int k = 0; k < 500; k++) begin
      gap = cordic_angle(-(1500 + 37 * k), -(900 + 23 * k)) -
            cordic_angle(1500 + 37 * k, 900 + 23 * k);
      if (gap == 16'h8000) begin
        hx = 1500 + 37 * k;
        hy = 900 + 23 * k;
        break;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_item(1'b1, 5000, 0, 0, 32'd0, 1'b0);
    push_item(1'b0, -32768, 32767, -32768, 32'd100, 1'b1);
    push_item(1'b1, 4000, 3000, 0, 32'd120, 1'b1);
    push_item(1'b1, 4000, 3000, 0, 32'd150, 1'b0);
    push_item(1'b1, 3000, 4000, 32767, 32'd200, 1'b0);
    push_item(1'b1, 3000, 4000, -32768, 32'd250, 1'b0);
    push_item(1'b1, -3000, 4000, 1920, 32'd300, 1'b0);
    push_item(1'b1, -3000, 4000, -1921, 32'd350, 1'b0);
    push_item(1'b1, 100, -100, 0, 32'd400, 1'b0);
    push_item(1'b1, 32767, -32768, 0, 32'd450, 1'b0);
    push_item(1'b1, -32768, 32767, 0, 32'd500, 1'b0);
    push_item(1'b1, -32768, -32768, 0, 32'd800, 1'b0);
    push_item(1'b1, -32768, -32768, 0, 32'd1000, 1'b0);
    push_item(1'b0, 0, 0, 0, 32'd1100, 1'b0);
    push_item(1'b1, hx, hy, 0, 32'd1150, 1'b0);
    push_item(1'b1, -hx, -hy, 0, 32'd1200, 1'b0);
    push_item(1'b0, 0, 0, 0, 32'hFFFF_FFF0, 1'b0);
    push_item(1'b1, 6000, 0, 0, 32'hFFFF_FFF8, 1'b0);
    push_item(1'b1, 6000, 0, 0, 32'h0000_0020, 1'b0);
    push_item(1'b1, 6000, 0, 0, 32'h0000_00B0, 1'b0);
    push_item(1'b1, 0, 6000, 0, 32'h0000_0100, 1'b0);
    push_item(1'b1, 0, 6000, 0, 32'h0000_0400, 1'b0);
    wait_quiet();

    load_settings('{15'h7FFF, 31'd0, 15'd0, 10'h3FF, 16'd0});
    push_item(1'b0, 0, 0, 0, 32'd5000, 1'b0);
    push_item(1'b1, 0, 0, 0, 32'd5050, 1'b0);
    push_item(1'b1, 0, 0, 0, 32'd5100, 1'b0);
    push_item(1'b1, 0, 20000, 32767, 32'd5150, 1'b0);
    push_item(1'b1, -20000, 0, 0, 32'd5200, 1'b0);
    push_item(1'b1, 0, -20000, 0, 32'd5250, 1'b0);
    push_item(1'b1, 20000, 0, 0, 32'd5300, 1'b0);
    push_item(1'b1, 0, -20000, 0, 32'd5350, 1'b0);
    push_item(1'b1, -20000, 0, 0, 32'd5400, 1'b0);
    push_item(1'b1, -20000, 0, -32768, 32'd5450, 1'b0);
    wait_quiet();

    load_settings('{15'd0, 31'h7FFF_FFFF, 15'h7FFF, 10'd0, 16'hFFFF});
    random_phase(100);
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) load_settings('{trd_pkg::TILT_STOP_RESET, trd_pkg::REST_RADIUS_RESET,
                                  trd_pkg::MIN_STEP_RESET, trd_pkg::LEVEL_GAIN_RESET,
                                  trd_pkg::SETTLE_RESET});
      else load_settings(random_settings());
      calm = (p == 3);
      random_phase(300);
      wait_quiet();
      calm = 1'b0;
    end

    repeat (30) @(posedge clk);
    if (awaited_verdicts.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_verdicts.size());
    end
    $display("Covered %0d transactions under %0d register settings.", accepted, settings_used);
    $display("Results seen: %0d level sends, %0d tilt stops, %0d wake extensions.",
             sends, stops, extensions);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[tilt_rotation_dimmer.f]
src/trd_pkg.sv
src/trd_front.sv
src/trd_queue.sv
src/trd_back.sv
src/tilt_rotation_dimmer.sv
bench/tilt_rotation_dimmer_tb.sv
